[hw/rtl/ptt_pkg.sv]
package ptt_pkg;

    localparam int TABLE_SLOTS = 128;
    localparam int SLOT_W      = 7;
    localparam int FRAME_W     = 8;
    localparam int FLAGS_W     = 3;
    localparam int PA_W        = 14;
    localparam int VA_W        = 32;
    localparam int COUNT_W     = 8;

    localparam int FLAG_RO    = 0;
    localparam int FLAG_USED  = 1;
    localparam int FLAG_DIRTY = 2;

    typedef enum logic [1:0] {
        CMD_WRITE_ENTRY = 2'd0,
        CMD_TRANSLATE   = 2'd1,
        CMD_READ_ENTRY  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_ADDRESS   = 2'd1,
        FAULT_READ_ONLY = 2'd2,
        FAULT_BUS       = 2'd3
    } fault_t;

endpackage

[hw/rtl/ptt_ram.sv]
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/page_table_translate.sv]
// An accepted beat is registered into the table read and the lookup stage, then
// into the output register; in_stall stays high and no new beat is taken until the
// previous one has left the lookup stage. The table read is followed by the flag write-back.
// A stalled output holds the result; the next beat is taken as soon as it is parked.
// Reset clears the valid flags and the page limit to 0; table contents are
// undefined until written.
module page_table_translate #(
    parameter int PAGE_BYTES  = 128,
    parameter int PHYS_FRAMES = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ptt_pkg::COUNT_W-1:0]  pages_in_use,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic [ptt_pkg::VA_W-1:0]     virtual_address,
    input  logic                         is_write,
    input  logic [ptt_pkg::SLOT_W-1:0]   slot_index,
    input  logic [ptt_pkg::FRAME_W-1:0]  slot_frame,
    input  logic                         slot_read_only,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ptt_pkg::PA_W-1:0]     physical_address,
    output logic [1:0]                   fault,
    output logic                         was_used,
    output logic                         was_dirty
);

    import ptt_pkg::*;

    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int VPN_W = VA_W - OFF_W;
    localparam int CAT_W = FRAME_W + OFF_W + PA_W;

    typedef struct packed {
        cmd_t             cmd;
        logic             wr;
        logic             addr_err;
        logic [SLOT_W-1:0] idx;
        logic [OFF_W-1:0] off;
    } stage_t;

    logic [COUNT_W-1:0] limit_reg;
    logic               busy_reg;
    stage_t             stage_reg;
    logic               out_valid_reg;
    logic [PA_W-1:0]    pa_reg;
    fault_t             fault_reg;
    logic               used_reg;
    logic               dirty_reg;

    logic               accept;
    logic               done;
    cmd_t               cmd_in;
    logic [VPN_W-1:0]   vpn;
    logic [SLOT_W-1:0]  rd_idx;
    logic [FRAME_W-1:0] frame_rd;
    logic [FLAGS_W-1:0] flags_rd;

    logic               frame_we;
    logic               flags_we;
    logic [SLOT_W-1:0]  flags_waddr;
    logic [FLAGS_W-1:0] flags_wdata;

    logic [PA_W-1:0]    pa_next;
    fault_t             fault_next;
    logic               used_next;
    logic               dirty_next;
    logic               mark_ok;
    logic [CAT_W-1:0]   pa_wide;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg;
    assign accept    = in_valid && !busy_reg;
    assign done      = busy_reg && (!out_valid_reg || !out_stall);
    assign cmd_in    = cmd_t'(command);
    assign vpn       = virtual_address[VA_W-1:OFF_W];
    assign rd_idx    = (cmd_in == CMD_TRANSLATE) ? vpn[SLOT_W-1:0] : slot_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= (pages_in_use > COUNT_W'(TABLE_SLOTS)) ?
                             COUNT_W'(TABLE_SLOTS) : pages_in_use;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.cmd      <= cmd_in;
            stage_reg.wr       <= is_write;
            stage_reg.addr_err <= vpn >= VPN_W'(limit_reg);
            stage_reg.idx      <= rd_idx;
            stage_reg.off      <= virtual_address[OFF_W-1:0];
        end
        if (done)
        begin
            pa_reg    <= pa_next;
            fault_reg <= fault_next;
            used_reg  <= used_next;
            dirty_reg <= dirty_next;
        end
    end

    assign frame_we = accept && (cmd_in == CMD_WRITE_ENTRY);

    ptt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (TABLE_SLOTS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (slot_index),
        .wdata (slot_frame),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (frame_rd)
    );

    ptt_ram #(
        .WIDTH (FLAGS_W),
        .DEPTH (TABLE_SLOTS)
    ) u_flags_ram (
        .clk   (clk),
        .we    (flags_we),
        .waddr (flags_waddr),
        .wdata (flags_wdata),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (flags_rd)
    );

    assign pa_wide = {{PA_W{1'b0}}, frame_rd, stage_reg.off};

    always_comb
    begin
        pa_next    = '0;
        fault_next = FAULT_NONE;
        used_next  = 1'b0;
        dirty_next = 1'b0;
        mark_ok    = 1'b0;
        unique case (stage_reg.cmd)
            CMD_TRANSLATE:
            begin
                priority if (stage_reg.addr_err)
                begin
                    fault_next = FAULT_ADDRESS;
                end
                else if (stage_reg.wr && flags_rd[FLAG_RO])
                begin
                    fault_next = FAULT_READ_ONLY;
                end
                else if ({1'b0, frame_rd} >= (FRAME_W+1)'(PHYS_FRAMES))
                begin
                    fault_next = FAULT_BUS;
                end
                else
                begin
                    mark_ok = 1'b1;
                    pa_next = pa_wide[PA_W-1:0];
                end
            end
            CMD_READ_ENTRY:
            begin
                used_next  = flags_rd[FLAG_USED];
                dirty_next = flags_rd[FLAG_DIRTY];
            end
            default:
            begin
                pa_next = '0;
            end
        endcase
    end

    always_comb
    begin
        flags_we    = 1'b0;
        flags_waddr = slot_index;
        flags_wdata = '0;
        if (frame_we)
        begin
            flags_we             = 1'b1;
            flags_wdata[FLAG_RO] = slot_read_only;
        end
        else if (done && mark_ok)
        begin
            flags_we                = 1'b1;
            flags_waddr             = stage_reg.idx;
            flags_wdata             = flags_rd;
            flags_wdata[FLAG_USED]  = 1'b1;
            flags_wdata[FLAG_DIRTY] = flags_rd[FLAG_DIRTY] | stage_reg.wr;
        end
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = pa_reg;
    assign fault            = fault_reg;
    assign was_used         = used_reg;
    assign was_dirty        = dirty_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && !out_valid_reg || busy_reg)
        else $error("accepted beat did not enter the lookup stage");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid_reg && !busy_reg)
        else $error("finished lookup did not reach the output register");

    a_fault_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fault_reg != FAULT_NONE) |-> physical_address == '0)
        else $error("faulting translation returned a nonzero address");

    a_mark_write: assert property (@(posedge clk) disable iff (!rst_n)
        flags_we && !frame_we |-> done && (stage_reg.cmd == CMD_TRANSLATE)
            && !stage_reg.addr_err)
        else $error("flag write-back outside a successful translation");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pa_reg) && $stable(fault_reg))
        else $error("parked result changed under stall");

endmodule

[tb/sv/tb_page_table_translate.sv]
`timescale 1ns / 1ps

module tb_page_table_translate;
    import ptt_pkg::*;

    localparam int PAGE_BYTES  = 128;
    localparam int PHYS_FRAMES = 128;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [VA_W-1:0]    va;
        logic               wr;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame;
        logic               ro;
    } beat_t;

    typedef struct packed {
        logic [PA_W-1:0] pa;
        logic [1:0]      fault;
        logic            used;
        logic            dirty;
    } xlate_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_pages = '0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          command = '0;
    logic [VA_W-1:0]     virtual_address = '0;
    logic                is_write = 1'b0;
    logic [SLOT_W-1:0]   slot_index = '0;
    logic [FRAME_W-1:0]  slot_frame = '0;
    logic                slot_read_only = 1'b0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [PA_W-1:0]     physical_address;
    logic [1:0]          fault;
    logic                was_used;
    logic                was_dirty;

    // predictor state
    logic [FRAME_W-1:0]  pt_frame [TABLE_SLOTS];
    logic [FLAGS_W-1:0]  pt_flags [TABLE_SLOTS];
    logic [COUNT_W-1:0]  page_limit = '0;

    // generator view: which slots hold a defined entry
    bit                  gen_written [TABLE_SLOTS];
    logic [COUNT_W-1:0]  gen_limit = '0;

    beat_t               pending_beats [$];
    xlate_t              expected_results [$];
    beat_t               cur_beat;
    int                  mismatches = 0;
    int                  idle_mode = 0;
    int                  hold_req = 0;
    int                  hold_ack = 0;
    int                  hold_left = 0;

    page_table_translate #(
        .PAGE_BYTES  (PAGE_BYTES),
        .PHYS_FRAMES (PHYS_FRAMES)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .pages_in_use     (cfg_pages),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .virtual_address  (virtual_address),
        .is_write         (is_write),
        .slot_index       (slot_index),
        .slot_frame       (slot_frame),
        .slot_read_only   (slot_read_only),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .physical_address (physical_address),
        .fault            (fault),
        .was_used         (was_used),
        .was_dirty        (was_dirty)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int page_cap(input logic [COUNT_W-1:0] v);
        return (v > TABLE_SLOTS) ? TABLE_SLOTS : int'(v);
    endfunction

    function automatic xlate_t translate_beat(input beat_t b);
        xlate_t            res;
        logic [VA_W-1:0]   vpn;
        logic [VA_W-1:0]   off;
        logic [VA_W-1:0]   full;
        logic [SLOT_W-1:0] idx;
        res = '0;
        vpn = b.va / PAGE_BYTES;
        off = b.va % PAGE_BYTES;
        case (b.cmd)
            CMD_WRITE_ENTRY:
            begin
                pt_frame[b.slot] = b.frame;
                pt_flags[b.slot] = '0;
                pt_flags[b.slot][FLAG_RO] = b.ro;
            end
            CMD_TRANSLATE:
            begin
                idx = vpn[SLOT_W-1:0];
                if (vpn >= page_cap(page_limit))
                    res.fault = FAULT_ADDRESS;
                else if (b.wr && pt_flags[idx][FLAG_RO])
                    res.fault = FAULT_READ_ONLY;
                else if (pt_frame[idx] >= PHYS_FRAMES)
                    res.fault = FAULT_BUS;
                else
                begin
                    pt_flags[idx][FLAG_USED] = 1'b1;
                    if (b.wr)
                        pt_flags[idx][FLAG_DIRTY] = 1'b1;
                    full = pt_frame[idx] * PAGE_BYTES + off;
                    res.pa = full[PA_W-1:0];
                end
            end
            CMD_READ_ENTRY:
            begin
                res.used  = pt_flags[b.slot][FLAG_USED];
                res.dirty = pt_flags[b.slot][FLAG_DIRTY];
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    function automatic beat_t mk_beat(input logic [1:0] c, input logic [VA_W-1:0] va,
                                      input logic wr, input logic [SLOT_W-1:0] s,
                                      input logic [FRAME_W-1:0] f, input logic ro);
        beat_t b;
        b.cmd = c;
        b.va = va;
        b.wr = wr;
        b.slot = s;
        b.frame = f;
        b.ro = ro;
        return b;
    endfunction

    // mostly legal accesses to mapped pages; unmapped slots get mapped first
    function automatic beat_t random_beat();
        beat_t           b;
        int              roll;
        int              pick;
        int              lim;
        logic [VA_W-1:0] vpn;
        b.va = $urandom;
        b.wr = 1'($urandom_range(0, 1));
        b.slot = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
        b.frame = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom_range(128, 255))
                                              : FRAME_W'($urandom_range(0, 127));
        b.ro = ($urandom_range(0, 9) < 3);
        roll = $urandom_range(0, 99);
        if (roll < 25)
            b.cmd = CMD_WRITE_ENTRY;
        else if (roll < 75)
            b.cmd = CMD_TRANSLATE;
        else if (roll < 95)
            b.cmd = CMD_READ_ENTRY;
        else
            b.cmd = CMD_UNKNOWN;
        lim = page_cap(gen_limit);
        if (b.cmd == CMD_TRANSLATE)
        begin
            pick = $urandom_range(0, 99);
            if (lim > 0 && pick < 80)
                vpn = $urandom_range(0, lim - 1);
            else if (pick < 90)
                vpn = b.va / PAGE_BYTES;
            else
                vpn = lim + $urandom_range(0, 3);
            b.va = vpn * PAGE_BYTES + (b.va % PAGE_BYTES);
            if (vpn < lim && !gen_written[vpn[SLOT_W-1:0]])
            begin
                b.cmd = CMD_WRITE_ENTRY;
                b.slot = vpn[SLOT_W-1:0];
            end
        end
        if (b.cmd == CMD_READ_ENTRY && !gen_written[b.slot])
            b.cmd = CMD_WRITE_ENTRY;
        return b;
    endfunction

    task automatic queue_beat(input beat_t b);
        if (b.cmd == CMD_WRITE_ENTRY)
            gen_written[b.slot] = 1'b1;
        pending_beats.push_back(b);
    endtask

    // sampled at the falling edge so the driver and monitor updates have landed
    task automatic settle();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_page_count(input logic [COUNT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_pages <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        page_limit = v;
        gen_limit = v;
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int mode, input logic [COUNT_W-1:0] pages,
                             input int n, input bit long_hold);
        write_page_count(pages);
        idle_mode <= mode;
        repeat (n) queue_beat(random_beat());
        if (long_hold)
        begin
            @(posedge clk);
            hold_req <= hold_req + 1;
        end
        settle();
    endtask

    function automatic bit sender_idle();
        case (idle_mode)
            1: return $urandom_range(0, 99) < 57;
            3: return $urandom_range(0, 99) < 35;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idle();
        case (idle_mode)
            2: return $urandom_range(0, 99) < 57;
            3: return $urandom_range(0, 99) < 35;
            default: return 1'b0;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(translate_beat(cur_beat));
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && !sender_idle())
                begin
                    cur_beat = pending_beats.pop_front();
                    in_valid        <= 1'b1;
                    command         <= cur_beat.cmd;
                    virtual_address <= cur_beat.va;
                    is_write        <= cur_beat.wr;
                    slot_index      <= cur_beat.slot;
                    slot_frame      <= cur_beat.frame;
                    slot_read_only  <= cur_beat.ro;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_ack  <= 0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= 160;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= receiver_idle();
    end

    // monitor
    always @(posedge clk)
    begin : check_results
        xlate_t want;
        xlate_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pa: physical_address, fault: fault, used: was_used, dirty: was_dirty};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: pa=%h fault=%0d used=%0b dirty=%0b",
                             got.pa, got.fault, got.used, got.dirty);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pa %h/%h fault %0d/%0d used %0b/%0b dirty %0b/%0b",
                                 want.pa, got.pa, want.fault, got.fault,
                                 want.used, got.used, want.dirty, got.dirty);
                end
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            pt_frame[i] = '0;
            pt_flags[i] = '0;
            gen_written[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_page_count(8'd128);
        queue_beat(mk_beat(CMD_WRITE_ENTRY, 32'h0, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_WRITE_ENTRY, 32'h0, 1'b0, 7'd127, 8'd127, 1'b1));
        queue_beat(mk_beat(CMD_WRITE_ENTRY, 32'h0, 1'b0, 7'd5, 8'd128, 1'b0));
        queue_beat(mk_beat(CMD_WRITE_ENTRY, 32'h0, 1'b0, 7'd6, 8'd255, 1'b1));
        queue_beat(mk_beat(CMD_TRANSLATE, 32'h0, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 127 * PAGE_BYTES + 127, 1'b1, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 127 * PAGE_BYTES + 127, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 5 * PAGE_BYTES + 3, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 6 * PAGE_BYTES, 1'b1, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 128 * PAGE_BYTES, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 32'h55, 1'b1, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_READ_ENTRY, 32'h0, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_READ_ENTRY, 32'h0, 1'b0, 7'd127, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_READ_ENTRY, 32'h0, 1'b0, 7'd5, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 7'd127, 8'd255, 1'b1));
        queue_beat(mk_beat(CMD_WRITE_ENTRY, 32'h0, 1'b0, 7'd0, 8'd64, 1'b0));
        queue_beat(mk_beat(CMD_READ_ENTRY, 32'h0, 1'b0, 7'd0, 8'd0, 1'b0));
        settle();

        write_page_count(8'd0);
        queue_beat(mk_beat(CMD_TRANSLATE, 32'h0, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_READ_ENTRY, 32'h0, 1'b0, 7'd0, 8'd0, 1'b0));
        settle();

        // count above the table saturates
        write_page_count(8'd255);
        queue_beat(mk_beat(CMD_TRANSLATE, 127 * PAGE_BYTES + 9, 1'b0, 7'd0, 8'd0, 1'b0));
        queue_beat(mk_beat(CMD_TRANSLATE, 128 * PAGE_BYTES, 1'b0, 7'd0, 8'd0, 1'b0));
        settle();

        run_phase(0, 8'd128, 220, 1'b1);
        run_phase(1, 8'd255, 220, 1'b0);
        run_phase(2, COUNT_W'($urandom_range(1, 127)), 220, 1'b0);
        run_phase(3, 8'd129, 220, 1'b0);
        run_phase(0, 8'd1, 100, 1'b0);
        run_phase(3, COUNT_W'($urandom_range(0, 255)), 300, 1'b0);

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
